// ----- rtl/line_pattern_first_last_finder_top_defines.svh -----
// ----------------------------------------------------------------------------
// line pattern finder assertion macros
// shared assertion forms, clocked on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef LINE_PATTERN_FIRST_LAST_FINDER_TOP_DEFINES_SVH
`define LINE_PATTERN_FIRST_LAST_FINDER_TOP_DEFINES_SVH

// same-cycle implication
`define LPFLF_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpflf assertion failed");

// next-cycle implication
`define LPFLF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpflf assertion failed");

`endif

// ----- rtl/lpflf_pkg.sv -----
// ----------------------------------------------------------------------------
// lpflf_pkg
// shared constants, register codes and character compare for the finder
// ----------------------------------------------------------------------------
package lpflf_pkg;

    localparam int MAX_PATTERN_DEF      = 23;
    localparam int LINE_NUMBER_BITS_DEF = 16;

    // pattern storage is fixed by the register map
    localparam int PAT_BYTES    = 23;
    localparam int PAT_LEN_BITS = 5;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 64;
    localparam int HIGH_BITS    = 56;

    localparam int FIELD_LINE_BITS  = 17;
    localparam int FIELD_COUNT_BITS = 16;

    localparam logic [7:0] NEWLINE_BYTE = 8'd10;
    localparam logic [7:0] CASE_GAP     = 8'd32;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;

    localparam logic [FIELD_LINE_BITS-1:0] NO_MATCH_LINE = '1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PAT_LOW  = 2'd0,
        CFG_PAT_MID  = 2'd1,
        CFG_PAT_HIGH = 2'd2,
        CFG_PAT_LEN  = 2'd3
    } cfg_index_t;

    typedef logic [7:0] byte_t;

    // letters match either case, anything else must be equal
    function automatic logic char_match(input byte_t p, input byte_t t);
        logic is_lower;
        logic is_upper;
        is_lower = p inside {[CHAR_LOWER_A:CHAR_LOWER_Z]};
        is_upper = p inside {[CHAR_UPPER_A:CHAR_UPPER_Z]};
        return (t == p) || (is_lower && (t == p - CASE_GAP))
               || (is_upper && (t == p + CASE_GAP));
    endfunction

endpackage

// ----- rtl/lpflf_text_if.sv -----
// ----------------------------------------------------------------------------
// lpflf_text_if
// text byte channel: one byte per word plus end-of-text mark
// ----------------------------------------------------------------------------
interface lpflf_text_if;
    logic                 valid;
    logic                 ready;
    lpflf_pkg::byte_t     text_byte;
    logic                 last_byte;

    modport source (output valid, output text_byte, output last_byte, input ready);
    modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

// ----- rtl/lpflf_result_if.sv -----
// ----------------------------------------------------------------------------
// lpflf_result_if
// result channel: first and last matching line and line count
// ----------------------------------------------------------------------------
interface lpflf_result_if;
    logic                                          valid;
    logic                                          ready;
    logic signed [lpflf_pkg::FIELD_LINE_BITS-1:0]  first_line;
    logic signed [lpflf_pkg::FIELD_LINE_BITS-1:0]  last_line;
    logic [lpflf_pkg::FIELD_COUNT_BITS-1:0]        line_count;

    modport source (output valid, output first_line, output last_line,
                    output line_count, input ready);
    modport sink   (input valid, input first_line, input last_line,
                    input line_count, output ready);
endinterface

// ----- rtl/lpflf_matcher.sv -----
// ----------------------------------------------------------------------------
// lpflf_matcher
// parallel compare of the pattern against the newest bytes of the line
// ----------------------------------------------------------------------------
module lpflf_matcher #(
    parameter int MAX_PATTERN = lpflf_pkg::MAX_PATTERN_DEF,
    parameter int BIL_BITS    = $clog2(MAX_PATTERN + 1)
) (
    input  lpflf_pkg::byte_t                     pattern [lpflf_pkg::PAT_BYTES],
    input  logic [lpflf_pkg::PAT_LEN_BITS-1:0]   pat_len,
    input  lpflf_pkg::byte_t                     window [MAX_PATTERN],
    input  logic [BIL_BITS-1:0]                  bytes_in_line,
    output logic                                 hit
);

    localparam logic [lpflf_pkg::PAT_LEN_BITS-1:0] LEN_MAX =
        lpflf_pkg::PAT_LEN_BITS'(MAX_PATTERN);

    logic [lpflf_pkg::PAT_LEN_BITS-1:0] len_eff;
    logic [MAX_PATTERN-1:0]             pos_ok;

    assign len_eff = (pat_len > LEN_MAX) ? LEN_MAX : pat_len;

    // window slot w (newest first) meets pattern char len-1-w
    always_comb
    begin
        logic [lpflf_pkg::PAT_LEN_BITS-1:0] pidx;
        lpflf_pkg::byte_t                   pchar;
        for (int w = 0; w < MAX_PATTERN; w++)
        begin
            pidx  = len_eff - lpflf_pkg::PAT_LEN_BITS'(1)
                    - lpflf_pkg::PAT_LEN_BITS'(w);
            pchar = (pidx < lpflf_pkg::PAT_LEN_BITS'(lpflf_pkg::PAT_BYTES))
                    ? pattern[pidx] : '0;
            pos_ok[w] = (lpflf_pkg::PAT_LEN_BITS'(w) >= len_eff)
                        || lpflf_pkg::char_match(pchar, window[w]);
        end
    end

    assign hit = (&pos_ok)
                 && (lpflf_pkg::PAT_LEN_BITS'(bytes_in_line) >= len_eff);

endmodule

// ----- rtl/line_pattern_first_last_finder_top.sv -----
// ----------------------------------------------------------------------------
// line_pattern_first_last_finder_top
// case-insensitive pattern search over a text stream, reporting first and
// last matching lines and the line count at the end of each text
// ----------------------------------------------------------------------------
// usage
//   text: one byte per word, byte 10 ends a line, last_byte marks the end
//   result: one word per text, issued after the word carrying last_byte
//   cfg: write enable, register index and data; pattern low/mid/high bytes
//   and pattern length; written while no text is in flight
// timing
//   a byte is registered in the input stage on acceptance and processed from
//   there, which loads the result register; a last-marked byte waits there
//   while a held result blocks it
//   one byte per cycle unless a held result blocks a last-marked byte; all
//   window compares run in parallel, bounded by the window mux and and-tree
// reset
//   all stream state and the pattern registers clear, line number is one
// stall
//   a held result blocks only the next last-marked byte; ordinary bytes keep
//   flowing into the window while the result waits
// ----------------------------------------------------------------------------
`include "line_pattern_first_last_finder_top_defines.svh"

module line_pattern_first_last_finder_top #(
    parameter int MAX_PATTERN      = lpflf_pkg::MAX_PATTERN_DEF,
    parameter int LINE_NUMBER_BITS = lpflf_pkg::LINE_NUMBER_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    lpflf_text_if.sink                             text,
    lpflf_result_if.source                         result,
    input  logic                                   cfg_we,
    input  logic [lpflf_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [lpflf_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

    localparam int BIL_BITS = $clog2(MAX_PATTERN + 1);
    localparam logic [BIL_BITS-1:0]         BIL_MAX  = BIL_BITS'(MAX_PATTERN);
    localparam logic [LINE_NUMBER_BITS-1:0] LINE_MAX = '1;
    localparam logic [LINE_NUMBER_BITS-1:0] LINE_ONE = LINE_NUMBER_BITS'(1);

    // configuration
    logic [63:0]                            pat_low_reg;
    logic [63:0]                            pat_mid_reg;
    logic [lpflf_pkg::HIGH_BITS-1:0]        pat_high_reg;
    logic [lpflf_pkg::PAT_LEN_BITS-1:0]     pat_len_reg;
    lpflf_pkg::byte_t                       pattern [lpflf_pkg::PAT_BYTES];

    // input stage
    logic                                   s1_valid_reg;
    lpflf_pkg::byte_t                       s1_byte_reg;
    logic                                   s1_last_reg;
    logic                                   s1_adv;

    // stream state
    lpflf_pkg::byte_t                       window_reg [MAX_PATTERN];
    lpflf_pkg::byte_t                       window_shift [MAX_PATTERN];
    logic [BIL_BITS-1:0]                    bil_reg;
    logic [BIL_BITS-1:0]                    bil_inc;
    logic [LINE_NUMBER_BITS-1:0]            line_reg;
    logic [LINE_NUMBER_BITS-1:0]            line_next;
    logic                                   found_reg;
    logic                                   found_next;
    logic [LINE_NUMBER_BITS-1:0]            first_reg;
    logic [LINE_NUMBER_BITS-1:0]            first_next;
    logic [LINE_NUMBER_BITS-1:0]            last_reg;
    logic [LINE_NUMBER_BITS-1:0]            last_next;
    logic                                   hit;
    logic                                   is_newline;

    // result register
    logic                                   out_valid_reg;
    logic [lpflf_pkg::FIELD_LINE_BITS-1:0]  out_first_reg;
    logic [lpflf_pkg::FIELD_LINE_BITS-1:0]  out_last_reg;
    logic [lpflf_pkg::FIELD_COUNT_BITS-1:0] out_count_reg;
    logic [31:0]                            first_wide;
    logic [31:0]                            last_wide;
    logic [31:0]                            line_wide;

    // ---------------- configuration registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_mid_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (lpflf_pkg::cfg_index_t'(cfg_index))
                lpflf_pkg::CFG_PAT_LOW:  pat_low_reg  <= cfg_wdata;
                lpflf_pkg::CFG_PAT_MID:  pat_mid_reg  <= cfg_wdata;
                lpflf_pkg::CFG_PAT_HIGH: pat_high_reg <= cfg_wdata[lpflf_pkg::HIGH_BITS-1:0];
                lpflf_pkg::CFG_PAT_LEN:  pat_len_reg  <= cfg_wdata[lpflf_pkg::PAT_LEN_BITS-1:0];
                default:                 pat_len_reg  <= pat_len_reg;
            endcase
        end
    end

    always_comb
    begin
        for (int k = 0; k < lpflf_pkg::PAT_BYTES; k++)
        begin
            if (k < 8)
                pattern[k] = pat_low_reg[8*k +: 8];
            else if (k < 16)
                pattern[k] = pat_mid_reg[8*(k-8) +: 8];
            else
                pattern[k] = pat_high_reg[8*(k-16) +: 8];
        end
    end

    // ---------------- input stage ----------------
    // only a last-marked byte needs room in the result register
    assign s1_adv     = s1_valid_reg && (!s1_last_reg || !out_valid_reg || result.ready);
    assign text.ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (text.ready)
            s1_valid_reg <= text.valid;
    end

    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
        begin
            s1_byte_reg <= text.text_byte;
            s1_last_reg <= text.last_byte;
        end
    end

    // ---------------- match and line tracking ----------------
    assign is_newline = (s1_byte_reg == lpflf_pkg::NEWLINE_BYTE);
    assign bil_inc    = (bil_reg < BIL_MAX) ? bil_reg + BIL_BITS'(1) : bil_reg;

    always_comb
    begin
        window_shift[0] = s1_byte_reg;
        for (int i = 1; i < MAX_PATTERN; i++)
            window_shift[i] = window_reg[i-1];
    end

    lpflf_matcher #(
        .MAX_PATTERN (MAX_PATTERN),
        .BIL_BITS    (BIL_BITS)
    ) u_matcher (
        .pattern       (pattern),
        .pat_len       (pat_len_reg),
        .window        (window_shift),
        .bytes_in_line (bil_inc),
        .hit           (hit)
    );

    always_comb
    begin
        line_next  = line_reg;
        found_next = found_reg;
        first_next = first_reg;
        last_next  = last_reg;
        if (is_newline)
        begin
            if (line_reg != LINE_MAX)
                line_next = line_reg + LINE_ONE;
        end
        else if (hit)
        begin
            found_next = 1'b1;
            last_next  = line_reg;
            if (!found_reg)
                first_next = line_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PATTERN; i++)
                window_reg[i] <= '0;
            bil_reg   <= '0;
            line_reg  <= LINE_ONE;
            found_reg <= 1'b0;
            first_reg <= '0;
            last_reg  <= '0;
        end
        else if (s1_adv)
        begin
            if (s1_last_reg || is_newline)
                bil_reg <= '0;
            else
                bil_reg <= bil_inc;
            if (!is_newline)
                window_reg <= window_shift;
            if (s1_last_reg)
            begin
                line_reg  <= LINE_ONE;
                found_reg <= 1'b0;
                first_reg <= '0;
                last_reg  <= '0;
            end
            else
            begin
                line_reg  <= line_next;
                found_reg <= found_next;
                first_reg <= first_next;
                last_reg  <= last_next;
            end
        end
    end

    // ---------------- result register ----------------
    assign first_wide = 32'(first_next);
    assign last_wide  = 32'(last_next);
    assign line_wide  = 32'(line_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv && s1_last_reg)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_last_reg)
        begin
            out_first_reg <= found_next ? first_wide[lpflf_pkg::FIELD_LINE_BITS-1:0]
                                        : lpflf_pkg::NO_MATCH_LINE;
            out_last_reg  <= found_next ? last_wide[lpflf_pkg::FIELD_LINE_BITS-1:0]
                                        : lpflf_pkg::NO_MATCH_LINE;
            out_count_reg <= line_wide[lpflf_pkg::FIELD_COUNT_BITS-1:0];
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.first_line = out_first_reg;
    assign result.last_line  = out_last_reg;
    assign result.line_count = out_count_reg;

    // ---------------- assertions ----------------
    `LPFLF_ASSERT_NEXT(a_last_gives_result, s1_adv && s1_last_reg, out_valid_reg)
    `LPFLF_ASSERT_IMPLY(a_match_order, found_reg, first_reg <= last_reg)
    `LPFLF_ASSERT_IMPLY(a_line_nonzero, 1'b1, line_reg != '0)
    `LPFLF_ASSERT_IMPLY(a_bil_bound, 1'b1, bil_reg <= BIL_MAX)

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// streams random and directed texts through the line pattern finder, keeps
// its own line and match tracker and compares every result word with it
// ----------------------------------------------------------------------------
module tb_top;

    import lpflf_pkg::*;

    localparam int CLOCK_LIMIT    = 200000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int HOLD_CYCLES    = 400;
    localparam int RANDOM_WORDS   = 1650;
    localparam int BURST_NEWLINES = 20;

    localparam logic [LINE_NUMBER_BITS_DEF-1:0] LINE_LIMIT = '1;

    typedef struct packed {
        logic signed [FIELD_LINE_BITS-1:0] first_line;
        logic signed [FIELD_LINE_BITS-1:0] last_line;
        logic [FIELD_COUNT_BITS-1:0]       line_count;
    } summary_t;

    // tracks the current line, the window of recent bytes and the match lines
    class match_line_tracker;
        byte_t                          win [PAT_BYTES];
        int unsigned                    fill;
        logic [LINE_NUMBER_BITS_DEF-1:0] line_no;
        bit                             found;
        logic [LINE_NUMBER_BITS_DEF-1:0] first_hit;
        logic [LINE_NUMBER_BITS_DEF-1:0] last_hit;
        logic [63:0]                    pat_low;
        logic [63:0]                    pat_mid;
        logic [HIGH_BITS-1:0]           pat_high;
        logic [PAT_LEN_BITS-1:0]        pat_len;
        summary_t                       due_summaries [$];
        int                             errors;

        function new();
            pat_low  = '0;
            pat_mid  = '0;
            pat_high = '0;
            pat_len  = '0;
            errors   = 0;
            clear_text();
        endfunction

        function void clear_text();
            foreach (win[i])
                win[i] = 8'h00;
            fill      = 0;
            line_no   = 1;
            found     = 1'b0;
            first_hit = '0;
            last_hit  = '0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] d);
            case (idx)
                CFG_PAT_LOW:  pat_low  = d;
                CFG_PAT_MID:  pat_mid  = d;
                CFG_PAT_HIGH: pat_high = d[HIGH_BITS-1:0];
                CFG_PAT_LEN:  pat_len  = d[PAT_LEN_BITS-1:0];
                default:      ;
            endcase
        endfunction

        function bit same_char(byte_t p, byte_t t);
            if (t == p)
                return 1'b1;
            if (p >= CHAR_LOWER_A && p <= CHAR_LOWER_Z)
                return t == byte_t'(p - CASE_GAP);
            if (p >= CHAR_UPPER_A && p <= CHAR_UPPER_Z)
                return t == byte_t'(p + CASE_GAP);
            return 1'b0;
        endfunction

        function void take_byte(byte_t t, logic lst);
            int                      len;
            bit                      hit;
            logic [8*PAT_BYTES-1:0]  pat;
            summary_t                s;
            if (t == NEWLINE_BYTE)
            begin
                foreach (win[i])
                    win[i] = 8'h00;
                fill = 0;
                if (line_no != LINE_LIMIT)
                    line_no++;
            end
            else
            begin
                for (int i = PAT_BYTES - 1; i > 0; i--)
                    win[i] = win[i-1];
                win[0] = t;
                if (fill < PAT_BYTES)
                    fill++;
                len = (pat_len > PAT_BYTES) ? PAT_BYTES : int'(pat_len);
                pat = {pat_high, pat_mid, pat_low};
                hit = (fill >= len);
                // pattern byte 0 lines up with the oldest byte of the window span
                for (int i = 0; i < len && hit; i++)
                    if (!same_char(pat[8*i +: 8], win[len-1-i]))
                        hit = 1'b0;
                if (hit)
                begin
                    if (!found)
                        first_hit = line_no;
                    found    = 1'b1;
                    last_hit = line_no;
                end
            end
            if (lst)
            begin
                s.first_line = found ? FIELD_LINE_BITS'(first_hit) : NO_MATCH_LINE;
                s.last_line  = found ? FIELD_LINE_BITS'(last_hit) : NO_MATCH_LINE;
                s.line_count = FIELD_COUNT_BITS'(line_no);
                due_summaries.push_back(s);
                clear_text();
            end
        endfunction

        task report(input string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_summary(input logic signed [FIELD_LINE_BITS-1:0] f,
                           input logic signed [FIELD_LINE_BITS-1:0] l,
                           input logic [FIELD_COUNT_BITS-1:0] c);
            summary_t want;
            if (due_summaries.size() == 0)
                report($sformatf("unexpected result word: first %0d last %0d count %0d",
                                 f, l, c));
            else
            begin
                want = due_summaries.pop_front();
                if (f !== want.first_line)
                    report($sformatf("first_line %0d, want %0d", f, want.first_line));
                if (l !== want.last_line)
                    report($sformatf("last_line %0d, want %0d", l, want.last_line));
                if (c !== want.line_count)
                    report($sformatf("line_count %0d, want %0d", c, want.line_count));
            end
        endtask
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_IDX_BITS-1:0]   cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata;

    lpflf_text_if   text_ch ();
    lpflf_result_if result_ch ();

    match_line_tracker tracker;

    byte_t pat_buf [PAT_BYTES];
    int    cur_len;
    int    words_sent;
    bit    text_steady;
    bit    result_steady;
    bit    hold_request;
    int    cycles;

    line_pattern_first_last_finder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .text      (text_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CLOCK_LIMIT)
            @(posedge clk) cycles++;
        $display("FAILURE");
        $finish;
    end

    function automatic byte_t random_letter();
        case ($urandom_range(0, 5))
            0:       return 8'h61;
            1:       return 8'h62;
            2:       return 8'h41;
            3:       return 8'h42;
            4:       return 8'h40;
            default: return 8'h60;
        endcase
    endfunction

    function automatic byte_t filler_byte();
        if ($urandom_range(0, 3) != 0)
            return random_letter();
        return byte_t'($urandom_range(0, 255));
    endfunction

    function automatic void push_str(ref byte_t q[$], input string s);
        for (int i = 0; i < s.len(); i++)
            q.push_back(byte_t'(s[i]));
    endfunction

    function automatic void load_pattern(input string s);
        foreach (pat_buf[i])
            pat_buf[i] = (i < s.len()) ? byte_t'(s[i]) : 8'h00;
    endfunction

    // lines of filler around copies of the pattern, some case-flipped or broken, or lines of random bytes only
    function automatic void build_text(ref byte_t q[$]);
        bit    noise;
        int    lines;
        int    len;
        byte_t b;
        q.delete();
        noise = ($urandom_range(0, 7) == 0);
        lines = $urandom_range(1, 5);
        len   = (cur_len > PAT_BYTES) ? PAT_BYTES : cur_len;
        for (int ln = 0; ln < lines; ln++)
        begin
            if (ln > 0)
                q.push_back(NEWLINE_BYTE);
            if (noise)
                repeat ($urandom_range(0, 10))
                    q.push_back(byte_t'($urandom_range(0, 255)));
            else
            begin
                repeat (($urandom_range(0, 5) == 0) ? $urandom_range(0, 30)
                                                     : $urandom_range(0, 4))
                    q.push_back(filler_byte());
                if ($urandom_range(0, 1) == 1)
                begin
                    for (int i = 0; i < len; i++)
                    begin
                        b = pat_buf[i];
                        if ((b | 8'h20) >= CHAR_LOWER_A && (b | 8'h20) <= CHAR_LOWER_Z
                            && $urandom_range(0, 1) == 1)
                            b = b ^ CASE_GAP;
                        q.push_back(b);
                    end
                    if (len > 0 && $urandom_range(0, 5) == 0)
                        q[q.size() - 1 - $urandom_range(0, len - 1)] = filler_byte();
                end
                repeat ($urandom_range(0, 4))
                    q.push_back(filler_byte());
            end
        end
        if (q.size() == 0)
            q.push_back(filler_byte());
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic put_word(input byte_t b, input logic lst);
        int gap;
        gap = text_steady ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        text_ch.valid     <= 1'b1;
        text_ch.text_byte <= b;
        text_ch.last_byte <= lst;
        do
            @(posedge clk);
        while (!text_ch.ready);
        tracker.take_byte(b, lst);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input byte_t q[$]);
        foreach (q[i])
            put_word(q[i], i == q.size() - 1);
    endtask

    task automatic wait_idle();
        text_ch.valid <= 1'b0;
        while (tracker.due_summaries.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= d;
        @(negedge clk);
        cfg_we <= 1'b0;
        tracker.write_reg(idx, d);
        @(negedge clk);
    endtask

    task automatic apply_pattern(input int len);
        logic [8*PAT_BYTES-1:0] packed_pat;
        wait_idle();
        foreach (pat_buf[i])
            packed_pat[8*i +: 8] = pat_buf[i];
        cur_len = len;
        write_reg(CFG_PAT_LOW, packed_pat[63:0]);
        write_reg(CFG_PAT_MID, packed_pat[127:64]);
        write_reg(CFG_PAT_HIGH, CFG_DATA_BITS'(packed_pat[8*PAT_BYTES-1:128]));
        write_reg(CFG_PAT_LEN, CFG_DATA_BITS'(len[PAT_LEN_BITS-1:0]));
    endtask

    initial
    begin : result_sink
        int gap;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                gap = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            else
                gap = result_steady ? 0 : $urandom_range(0, 19);
            if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_ch.valid);
            tracker.check_summary(result_ch.first_line, result_ch.last_line,
                                  result_ch.line_count);
            if ($urandom_range(0, 5) == 0)
                result_steady = ~result_steady;
        end
    end

    initial
    begin : stimulus
        byte_t q[$];
        int    base;
        int    r;
        text_ch.valid     <= 1'b0;
        text_ch.text_byte <= 8'h00;
        text_ch.last_byte <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= '0;
        cfg_wdata         <= '0;
        rst_n             <= 1'b0;
        words_sent    = 0;
        cur_len       = 0;
        text_steady   = 1'b0;
        result_steady = 1'b0;
        hold_request  = 1'b0;
        tracker = new();
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty pattern after reset: any line with a byte matches
        q.delete(); push_str(q, "ab\n\nc"); send_text(q);
        q.delete(); push_str(q, "\n"); send_text(q);
        q = {8'h00}; send_text(q);

        // letters in either case, no match across a line break
        load_pattern("aB"); apply_pattern(2);
        q.delete(); push_str(q, "xAb\nab\nAB"); send_text(q);
        q.delete(); push_str(q, "a\nb"); send_text(q);

        // newline inside the pattern never matches
        load_pattern("a\n"); apply_pattern(2);
        q.delete(); push_str(q, "a\na"); send_text(q);

        // zero and all-ones bytes are plain characters
        load_pattern(""); pat_buf[0] = 8'h00; pat_buf[1] = 8'hFF; apply_pattern(2);
        q = {8'h00, 8'hFF}; send_text(q);

        // all register bits set, length clamped to the window
        foreach (pat_buf[i])
            pat_buf[i] = 8'hFF;
        apply_pattern(31);
        q = {8'hFF}; send_text(q);

        // run of empty lines, sent back to back
        load_pattern("a"); apply_pattern(1);
        text_steady = 1'b1;
        q.delete();
        q.push_back(8'h61);
        repeat (BURST_NEWLINES) q.push_back(NEWLINE_BYTE);
        q.push_back(8'h41);
        send_text(q);

        // receiver holds off while short texts keep coming
        load_pattern("ab"); apply_pattern(2);
        hold_request = 1'b1;
        repeat (8)
        begin
            build_text(q);
            send_text(q);
        end
        text_steady = 1'b0;

        base = words_sent;
        while (words_sent - base < RANDOM_WORDS)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                cur_len = 0;
            else if (r == 1)
                cur_len = $urandom_range(20, 31);
            else
                cur_len = $urandom_range(1, 5);
            foreach (pat_buf[i])
                pat_buf[i] = ($urandom_range(0, 3) == 0) ? byte_t'($urandom_range(0, 255))
                                                          : random_letter();
            apply_pattern(cur_len);
            repeat ($urandom_range(4, 12))
            begin
                if ($urandom_range(0, 4) == 0)
                    text_steady = ~text_steady;
                build_text(q);
                send_text(q);
            end
        end

        wait_idle();
        repeat (10) @(negedge clk);
        if (tracker.due_summaries.size() != 0)
            tracker.report($sformatf("%0d result words never arrived",
                                     tracker.due_summaries.size()));
        if (tracker.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
